@@ rtl/cspq_pkg.sv @@
// shared types and constants of the sorted candidate priority queue
// no dependencies; used by every other file of the block
package cspq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_W            = 32;
    localparam int DIST_W          = 32;
    localparam int COUNT_W         = 5;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_FIND  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] distance;
        logic              kind;
    } t_entry;

    typedef struct packed {
        logic ahead;
        logic id_eq;
    } t_cmp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH_RD,
        S_PUSH_EV,
        S_PUSH_WR,
        S_FIND_RD,
        S_FIND_EV,
        S_SHIFT_RD,
        S_SHIFT_EV,
        S_HEAD_RD,
        S_HEAD_EV,
        S_DONE
    } t_state;

    typedef struct packed {
        t_status             status;
        t_entry              res;
        logic                head_valid;
        t_entry              head;
        logic [COUNT_W-1:0]  count;
    } t_result;

endpackage

@@ rtl/cspq_mem.sv @@
// entry store: one write port, one read port with registered read data
// depends on cspq_pkg
module cspq_mem #(
    parameter int QUEUE_DEPTH = cspq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_wr_en,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_wr_addr,
    input  cspq_pkg::t_entry               i_wr_data,
    input  logic                           i_rd_en,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_rd_addr,
    output cspq_pkg::t_entry               o_rd_data
);

    cspq_pkg::t_entry r_mem [QUEUE_DEPTH];
    cspq_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/cspq_cmp.sv @@
// shared compare unit: rank order and id match of two entries
// depends on cspq_pkg
module cspq_cmp (
    input  cspq_pkg::t_entry i_a,
    input  cspq_pkg::t_entry i_b,
    output cspq_pkg::t_cmp   o_cmp
);

    logic w_dist_lt;
    logic w_dist_eq;

    assign w_dist_lt = i_a.distance < i_b.distance;
    assign w_dist_eq = i_a.distance == i_b.distance;

    // network ranks before router on equal distance
    assign o_cmp.ahead = w_dist_lt || (w_dist_eq && i_a.kind && !i_b.kind);
    assign o_cmp.id_eq = i_a.id == i_b.id;

endmodule

@@ rtl/cspq_seq.sv @@
// sequencer: walks the entry store one slot at a time through the compare unit
// depends on cspq_pkg, cspq_mem, cspq_cmp
module cspq_seq #(
    parameter int QUEUE_DEPTH = cspq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  cspq_pkg::t_op       i_op,
    input  cspq_pkg::t_entry    i_item,
    input  logic                i_out_free,
    output logic                o_busy,
    output logic                o_done,
    output cspq_pkg::t_result   o_result
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cspq_pkg::t_state  r_state, n_state;
    cspq_pkg::t_op     r_op, n_op;
    cspq_pkg::t_entry  r_item, n_item;
    cspq_pkg::t_entry  r_res, n_res;
    cspq_pkg::t_entry  r_head, n_head;
    cspq_pkg::t_status r_status, n_status;
    logic              r_head_valid, n_head_valid;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [IDX_W-1:0]  r_pos, n_pos;

    logic              w_wr_en;
    logic [IDX_W-1:0]  w_wr_addr;
    cspq_pkg::t_entry  w_wr_data;
    logic              w_rd_en;
    logic [IDX_W-1:0]  w_rd_addr;
    cspq_pkg::t_entry  w_rd_data;
    cspq_pkg::t_cmp    w_cmp;
    logic [IDX_W-1:0]  w_last;

    cspq_mem #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_mem (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(w_wr_data),
        .i_rd_en  (w_rd_en),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    cspq_cmp u_cmp (
        .i_a  (r_item),
        .i_b  (w_rd_data),
        .o_cmp(w_cmp)
    );

    // index of the last held entry
    assign w_last = IDX_W'(r_count - CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= cspq_pkg::S_IDLE;
            r_count      <= '0;
            r_head_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_head_valid <= n_head_valid;
        end
        r_op     <= n_op;
        r_item   <= n_item;
        r_res    <= n_res;
        r_head   <= n_head;
        r_status <= n_status;
        r_idx    <= n_idx;
        r_pos    <= n_pos;
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_item       = r_item;
        n_res        = r_res;
        n_head       = r_head;
        n_status     = r_status;
        n_head_valid = r_head_valid;
        n_count      = r_count;
        n_idx        = r_idx;
        n_pos        = r_pos;
        w_wr_en      = 1'b0;
        w_wr_addr    = r_idx;
        w_wr_data    = w_rd_data;
        w_rd_en      = 1'b0;
        w_rd_addr    = r_idx;
        o_done       = 1'b0;

        unique case (r_state)
            cspq_pkg::S_IDLE: begin
                if (i_start) begin
                    n_op     = i_op;
                    n_item   = i_item;
                    n_res    = '0;
                    n_status = cspq_pkg::STAT_OK;
                    unique case (i_op)
                        cspq_pkg::OP_PUSH: begin
                            if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                                n_status = cspq_pkg::STAT_FULL;
                                n_state  = cspq_pkg::S_DONE;
                            end else if (r_count == '0) begin
                                n_pos   = '0;
                                n_state = cspq_pkg::S_PUSH_WR;
                            end else begin
                                // scan from the tail toward the head
                                n_idx   = w_last;
                                n_state = cspq_pkg::S_PUSH_RD;
                            end
                        end
                        cspq_pkg::OP_POP: begin
                            if (r_count == '0) begin
                                n_status = cspq_pkg::STAT_EMPTY;
                                n_state  = cspq_pkg::S_DONE;
                            end else if (r_count == CNT_W'(1)) begin
                                n_res   = r_head;
                                n_count = '0;
                                n_state = cspq_pkg::S_HEAD_RD;
                            end else begin
                                n_res   = r_head;
                                n_idx   = IDX_W'(1);
                                n_state = cspq_pkg::S_SHIFT_RD;
                            end
                        end
                        cspq_pkg::OP_FIND: begin
                            if (r_count == '0) begin
                                n_status = cspq_pkg::STAT_NOT_FOUND;
                                n_state  = cspq_pkg::S_DONE;
                            end else begin
                                n_idx   = '0;
                                n_state = cspq_pkg::S_FIND_RD;
                            end
                        end
                        cspq_pkg::OP_CLEAR: begin
                            n_count      = '0;
                            n_head_valid = 1'b0;
                            n_state      = cspq_pkg::S_DONE;
                        end
                        default: begin
                            n_state = cspq_pkg::S_DONE;
                        end
                    endcase
                end
            end
            cspq_pkg::S_PUSH_RD: begin
                w_rd_en = 1'b1;
                n_state = cspq_pkg::S_PUSH_EV;
            end
            cspq_pkg::S_PUSH_EV: begin
                if (w_cmp.ahead) begin
                    // entry ranks after the new one: move it one slot back
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_idx + IDX_W'(1);
                    w_wr_data = w_rd_data;
                    if (r_idx == '0) begin
                        n_pos   = '0;
                        n_state = cspq_pkg::S_PUSH_WR;
                    end else begin
                        n_idx   = r_idx - IDX_W'(1);
                        n_state = cspq_pkg::S_PUSH_RD;
                    end
                end else begin
                    n_pos   = r_idx + IDX_W'(1);
                    n_state = cspq_pkg::S_PUSH_WR;
                end
            end
            cspq_pkg::S_PUSH_WR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_pos;
                w_wr_data = r_item;
                n_count   = r_count + CNT_W'(1);
                n_state   = cspq_pkg::S_HEAD_RD;
            end
            cspq_pkg::S_FIND_RD: begin
                w_rd_en = 1'b1;
                n_state = cspq_pkg::S_FIND_EV;
            end
            cspq_pkg::S_FIND_EV: begin
                if (w_cmp.id_eq) begin
                    n_res    = w_rd_data;
                    n_status = cspq_pkg::STAT_OK;
                    n_state  = cspq_pkg::S_DONE;
                end else if (r_idx == w_last) begin
                    n_status = cspq_pkg::STAT_NOT_FOUND;
                    n_state  = cspq_pkg::S_DONE;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = cspq_pkg::S_FIND_RD;
                end
            end
            cspq_pkg::S_SHIFT_RD: begin
                w_rd_en = 1'b1;
                n_state = cspq_pkg::S_SHIFT_EV;
            end
            cspq_pkg::S_SHIFT_EV: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_idx - IDX_W'(1);
                w_wr_data = w_rd_data;
                if (r_idx == w_last) begin
                    n_count = r_count - CNT_W'(1);
                    n_state = cspq_pkg::S_HEAD_RD;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = cspq_pkg::S_SHIFT_RD;
                end
            end
            cspq_pkg::S_HEAD_RD: begin
                if (r_count == '0) begin
                    n_head_valid = 1'b0;
                    n_state      = cspq_pkg::S_DONE;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = '0;
                    n_state   = cspq_pkg::S_HEAD_EV;
                end
            end
            cspq_pkg::S_HEAD_EV: begin
                n_head       = w_rd_data;
                n_head_valid = 1'b1;
                n_state      = cspq_pkg::S_DONE;
            end
            cspq_pkg::S_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = cspq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cspq_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = r_state != cspq_pkg::S_IDLE;

    always_comb begin
        o_result.status     = r_status;
        o_result.res        = r_res;
        o_result.head_valid = r_head_valid;
        o_result.head       = r_head_valid ? r_head : '0;
        o_result.count      = cspq_pkg::COUNT_W'(r_count);
    end

endmodule

@@ rtl/sorted_candidate_priority_queue_top.sv @@
// Sorted candidate priority queue. Holds up to QUEUE_DEPTH shortest-path
// candidates (vertex id, distance, kind) in a single-port-per-side entry
// memory, kept sorted by distance ascending with network entries ahead of
// router entries at equal distance; equal keys leave first in, first out.
// Operations are push, pop, find by id and clear; each beat in gives exactly
// one beat out carrying a status, the popped or found entry, the head after
// the operation and the entry count (low 5 bits). One operation is worked at
// a time by a small sequencer that walks the memory one slot at a time
// (read, then compare or move) through one shared compare unit, so the cost
// follows the number of slots visited. The input opens again as the result
// is loaded, later if the result has to wait for the output register to
// drain. A finished result waits in the output register while the next
// beat is accepted; the block stalls its input while an operation is in
// flight. No clearing pass is needed after reset: only slots below the count
// are ever read.
// depends on cspq_pkg, cspq_seq
module sorted_candidate_priority_queue_top #(
    parameter int QUEUE_DEPTH = cspq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // operation channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_operation,
    input  logic [cspq_pkg::ID_W-1:0]    i_vertex_id,
    input  logic [cspq_pkg::DIST_W-1:0]  i_distance,
    input  logic                         i_vertex_type,
    // result channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [1:0]                   o_status,
    output logic [cspq_pkg::ID_W-1:0]    o_result_id,
    output logic [cspq_pkg::DIST_W-1:0]  o_result_distance,
    output logic                         o_result_type,
    output logic                         o_head_valid,
    output logic [cspq_pkg::ID_W-1:0]    o_head_id,
    output logic [cspq_pkg::DIST_W-1:0]  o_head_distance,
    output logic                         o_head_type,
    output logic [cspq_pkg::COUNT_W-1:0] o_entry_count
);

    logic              w_busy;
    logic              w_start;
    logic              w_done;
    logic              w_out_free;
    cspq_pkg::t_entry  w_item;
    cspq_pkg::t_result w_result;

    // output register
    logic              r_out_valid;
    cspq_pkg::t_result r_out;

    // a beat is taken only while the sequencer is idle
    assign o_stall = w_busy;
    assign w_start = i_valid && !w_busy;

    assign w_item.id       = i_vertex_id;
    assign w_item.distance = i_distance;
    assign w_item.kind     = i_vertex_type;

    // the sequencer may hand over a result once the output register drains
    assign w_out_free = !r_out_valid || !i_stall;

    cspq_seq #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_op      (cspq_pkg::t_op'(i_operation)),
        .i_item    (w_item),
        .i_out_free(w_out_free),
        .o_busy    (w_busy),
        .o_done    (w_done),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_done) begin
            r_out <= w_result;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_out.status;
    assign o_result_id       = r_out.res.id;
    assign o_result_distance = r_out.res.distance;
    assign o_result_type     = r_out.res.kind;
    assign o_head_valid      = r_out.head_valid;
    assign o_head_id         = r_out.head.id;
    assign o_head_distance   = r_out.head.distance;
    assign o_head_type       = r_out.head.kind;
    assign o_entry_count     = r_out.count;

endmodule

@@ rtl/cspq_chk.sv @@
// port-level checks of the sorted candidate priority queue
// depends on cspq_pkg; bound to sorted_candidate_priority_queue_top
module cspq_chk #(
    parameter int QUEUE_DEPTH = cspq_pkg::QUEUE_DEPTH_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_stall,
    input logic [1:0]                   i_operation,
    input logic [cspq_pkg::ID_W-1:0]    i_vertex_id,
    input logic [cspq_pkg::DIST_W-1:0]  i_distance,
    input logic                         i_vertex_type,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic [1:0]                   o_status,
    input logic [cspq_pkg::ID_W-1:0]    o_result_id,
    input logic [cspq_pkg::DIST_W-1:0]  o_result_distance,
    input logic                         o_result_type,
    input logic                         o_head_valid,
    input logic [cspq_pkg::ID_W-1:0]    o_head_id,
    input logic [cspq_pkg::DIST_W-1:0]  o_head_distance,
    input logic                         o_head_type,
    input logic [cspq_pkg::COUNT_W-1:0] o_entry_count
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_result_id)
            && $stable(o_head_id) && $stable(o_entry_count))
        else $error("stalled result beat changed");

    // one operation at a time: an accepted beat stalls the input next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after accepted beat");

    // an empty queue shows a zero head
    a_empty_head_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_head_valid |-> o_head_id == '0 && o_head_distance == '0
            && o_head_type == 1'b0)
        else $error("head fields nonzero on empty queue");

    // empty pop leaves no head and no result
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == cspq_pkg::STAT_EMPTY |-> !o_head_valid
            && o_result_id == '0 && o_result_distance == '0 && o_result_type == 1'b0)
        else $error("empty status with head or result");

    // a dropped push only happens with a full, nonempty queue
    a_full_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == cspq_pkg::STAT_FULL |-> o_head_valid
            && o_entry_count == cspq_pkg::COUNT_W'(QUEUE_DEPTH))
        else $error("full status with wrong head or count");

endmodule

bind sorted_candidate_priority_queue_top cspq_chk #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
) u_cspq_chk (.*);

@@ dv/sorted_candidate_priority_queue_top_tb.sv @@
// self-checking testbench for the sorted candidate priority queue top level
// drives operation beats with random gaps, predicts every result beat and compares it
// depends on cspq_pkg and sorted_candidate_priority_queue_top
`timescale 1ns / 100ps

module sorted_candidate_priority_queue_top_tb;

    import cspq_pkg::*;

    localparam int QUEUE_DEPTH  = QUEUE_DEPTH_DEF;
    // receiver hold-off long enough to back the block up into its input
    localparam int LONG_HOLD_AT = 200;
    localparam int LONG_HOLD    = 300;
    // cycles with no beat accepted on either side before giving up
    localparam int IDLE_LIMIT   = 3000;
    // quiet cycles after the last result, a few times the slowest operation
    localparam int TAIL_CYCLES  = 100;

    // one pending operation beat plus how the sender paces it
    typedef struct {
        t_op               op;
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] distance;
        logic              kind;
        int unsigned       gap;
        bit                wait_drain;
    } t_op_beat;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_valid       = 1'b0;
    logic                o_stall;
    logic [1:0]          i_operation   = OP_PUSH;
    logic [ID_W-1:0]     i_vertex_id   = '0;
    logic [DIST_W-1:0]   i_distance    = '0;
    logic                i_vertex_type = 1'b0;
    logic                o_valid;
    logic                i_stall       = 1'b0;
    logic [1:0]          o_status;
    logic [ID_W-1:0]     o_result_id;
    logic [DIST_W-1:0]   o_result_distance;
    logic                o_result_type;
    logic                o_head_valid;
    logic [ID_W-1:0]     o_head_id;
    logic [DIST_W-1:0]   o_head_distance;
    logic                o_head_type;
    logic [COUNT_W-1:0]  o_entry_count;

    t_op_beat    pending_beats[$];
    t_result     expected_results[$];
    int unsigned n_accepted = 0;   // operation beats taken by the block
    int unsigned n_results  = 0;   // result beats taken from the block
    int unsigned n_errors   = 0;
    int unsigned rx_stall_left = 0;
    bit          long_hold_done = 0;
    int unsigned idle_cycles = 0;

    // shadow copy of the sorted queue
    t_entry      shadow_slot[QUEUE_DEPTH];
    int unsigned shadow_held = 0;

    sorted_candidate_priority_queue_top #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_operation      (i_operation),
        .i_vertex_id      (i_vertex_id),
        .i_distance       (i_distance),
        .i_vertex_type    (i_vertex_type),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_result_id      (o_result_id),
        .o_result_distance(o_result_distance),
        .o_result_type    (o_result_type),
        .o_head_valid     (o_head_valid),
        .o_head_id        (o_head_id),
        .o_head_distance  (o_head_distance),
        .o_head_type      (o_head_type),
        .o_entry_count    (o_entry_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // strict ranking: smaller distance first, network ahead of router on a tie
    function automatic bit ranks_ahead(t_entry a, t_entry b);
        return (a.distance < b.distance) ||
               (a.distance == b.distance && a.kind && !b.kind);
    endfunction

    // apply one accepted operation to the shadow queue and queue up its result
    task automatic queue_predict(input t_op op, input logic [ID_W-1:0] id,
                                 input logic [DIST_W-1:0] dist_val, input logic kind);
        t_result     r;
        t_entry      e;
        int unsigned pos;
        int unsigned i;
        r          = '0;
        r.status   = STAT_OK;
        e.id       = id;
        e.distance = dist_val;
        e.kind     = kind;
        case (op)
            OP_PUSH: begin
                if (shadow_held >= QUEUE_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    // insert behind everything that does not rank after the new entry
                    pos = shadow_held;
                    for (i = 0; i < shadow_held; i++) begin
                        if (ranks_ahead(e, shadow_slot[i])) begin
                            pos = i;
                            break;
                        end
                    end
                    for (i = shadow_held; i > pos; i--) begin
                        shadow_slot[i] = shadow_slot[i-1];
                    end
                    shadow_slot[pos] = e;
                    shadow_held++;
                end
            end
            OP_POP: begin
                if (shadow_held == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    r.res = shadow_slot[0];
                    for (i = 1; i < shadow_held; i++) begin
                        shadow_slot[i-1] = shadow_slot[i];
                    end
                    shadow_held--;
                end
            end
            OP_FIND: begin
                r.status = STAT_NOT_FOUND;
                for (i = 0; i < shadow_held; i++) begin
                    if (shadow_slot[i].id == id) begin
                        r.status = STAT_OK;
                        r.res    = shadow_slot[i];
                        break;
                    end
                end
            end
            default: begin
                shadow_held = 0;
            end
        endcase
        if (shadow_held > 0) begin
            r.head_valid = 1'b1;
            r.head       = shadow_slot[0];
        end
        r.count = shadow_held[COUNT_W-1:0];
        expected_results.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_errors++;
        end
    endtask

    task automatic add_beat(input t_op op, input logic [ID_W-1:0] id,
                            input logic [DIST_W-1:0] dist_val, input logic kind,
                            input int unsigned gap, input bit wait_drain);
        t_op_beat b;
        b.op         = op;
        b.id         = id;
        b.distance   = dist_val;
        b.kind       = kind;
        b.gap        = gap;
        b.wait_drain = wait_drain;
        pending_beats.push_back(b);
    endtask

    // driver: offers pending beats, holds a stalled beat, predicts on acceptance
    always @(posedge i_clk) begin
        bit          holding;
        int unsigned acc_total;
        t_op_beat    b;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            holding   = i_valid;
            acc_total = n_accepted;
            if (i_valid && !o_stall) begin
                queue_predict(t_op'(i_operation), i_vertex_id, i_distance, i_vertex_type);
                holding   = 1'b0;
                acc_total = n_accepted + 1;
                n_accepted <= acc_total;
            end
            if (!holding) begin
                if (pending_beats.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (pending_beats[0].gap > 0) begin
                    // per-beat gap before offering
                    pending_beats[0].gap = pending_beats[0].gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_beats[0].wait_drain && n_results != acc_total) begin
                    // pause until every outstanding result beat is back
                    i_valid <= 1'b0;
                end else begin
                    b = pending_beats[0];
                    pending_beats.delete(0);
                    i_operation   <= b.op;
                    i_vertex_id   <= b.id;
                    i_distance    <= b.distance;
                    i_vertex_type <= b.kind;
                    i_valid       <= 1'b1;
                end
            end
        end
    end

    // monitor: takes result beats, checks them, paces its own stall
    always @(posedge i_clk) begin
        t_result     want;
        int unsigned sl;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_stall_left = 0;
        end else begin
            sl = rx_stall_left;
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing expected");
                    n_errors++;
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    check_field("status", 32'(want.status), 32'(o_status));
                    check_field("result_id", want.res.id, o_result_id);
                    check_field("result_distance", want.res.distance, o_result_distance);
                    check_field("result_type", 32'(want.res.kind), 32'(o_result_type));
                    check_field("head_valid", 32'(want.head_valid), 32'(o_head_valid));
                    check_field("head_id", want.head.id, o_head_id);
                    check_field("head_distance", want.head.distance, o_head_distance);
                    check_field("head_type", 32'(want.head.kind), 32'(o_head_type));
                    check_field("entry_count", 32'(want.count), 32'(o_entry_count));
                end
                n_results <= n_results + 1;
                if (!long_hold_done && n_results == LONG_HOLD_AT) begin
                    // long hold-off so the block backs up and stalls its input
                    sl = LONG_HOLD;
                    long_hold_done = 1'b1;
                end else if (((n_results / 64) % 3) == 1) begin
                    // stretch with no receiver stall
                    sl = 0;
                end else begin
                    sl = $urandom_range(0, 17);
                end
            end else if (sl > 0) begin
                sl--;
            end
            rx_stall_left = sl;
            i_stall <= (sl != 0);
        end
    end

    // watchdog: no beat on either side for too long ends the run
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [ID_W-1:0]   id_pool[$];
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] dist_val;
        t_op               op;
        int unsigned       mode;
        int unsigned       roll;
        int unsigned       blk;
        int unsigned       k;
        bit                tx_quiet;
        bit                fresh;

        // empty queue corner cases
        add_beat(OP_POP,   32'h0, 32'h0, 1'b0, $urandom_range(0, 17), 1'b0);
        add_beat(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, $urandom_range(0, 17), 1'b0);

        // fill to the brim: extremes, ties on both kinds, duplicate id
        add_beat(OP_PUSH, 32'h0000_0000, 32'h0000_0000, 1'b0, 0, 1'b0);
        add_beat(OP_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 0, 1'b0);
        add_beat(OP_PUSH, 32'h0000_0001, 32'h0000_0000, 1'b1, 0, 1'b0);  // network jumps router
        add_beat(OP_PUSH, 32'h0000_0002, 32'h0000_0000, 1'b0, 0, 1'b0);  // router tie, in order
        add_beat(OP_PUSH, 32'h0000_0003, 32'h0000_0000, 1'b1, 0, 1'b0);  // network tie, in order
        add_beat(OP_PUSH, 32'hC0A8_0001, 32'h0000_0005, 1'b0, $urandom_range(0, 17), 1'b0);
        add_beat(OP_PUSH, 32'hC0A8_0002, 32'h0000_0005, 1'b1, 0, 1'b0);
        add_beat(OP_PUSH, 32'hC0A8_0001, 32'h0000_0003, 1'b1, 0, 1'b0);  // same id, ranks ahead
        add_beat(OP_PUSH, 32'h0A00_0001, 32'hFFFF_FFFF, 1'b0, 0, 1'b0);
        add_beat(OP_PUSH, 32'h0A00_0002, 32'hFFFF_FFFE, 1'b0, 0, 1'b0);
        add_beat(OP_PUSH, 32'h0A00_0003, 32'h0000_0007, 1'b0, $urandom_range(0, 17), 1'b0);
        add_beat(OP_PUSH, 32'h0A00_0004, 32'h0000_0007, 1'b0, 0, 1'b0);
        add_beat(OP_PUSH, 32'h0A00_0005, 32'h0000_0001, 1'b1, 0, 1'b0);
        add_beat(OP_PUSH, 32'h0A00_0006, 32'h0000_0002, 1'b0, 0, 1'b0);
        add_beat(OP_PUSH, 32'h0A00_0007, 32'h8000_0000, 1'b1, 0, 1'b0);
        add_beat(OP_PUSH, 32'h0A00_0008, 32'h7FFF_FFFF, 1'b0, 0, 1'b0);
        // full queue drops the push
        add_beat(OP_PUSH, 32'h0A00_00FF, 32'h0000_0000, 1'b1, 0, 1'b0);
        // find: first of two with the same id, a hit next to the tail, a miss
        add_beat(OP_FIND, 32'hC0A8_0001, 32'h0, 1'b0, $urandom_range(0, 17), 1'b0);
        add_beat(OP_FIND, 32'hFFFF_FFFF, 32'h0, 1'b0, 0, 1'b0);
        add_beat(OP_FIND, 32'h1234_5678, 32'h0, 1'b0, 0, 1'b0);
        add_beat(OP_POP,  32'h0, 32'h0, 1'b0, 0, 1'b0);
        // clear a queue one short of full, then pop and find on empty
        add_beat(OP_CLEAR, 32'h0, 32'h0, 1'b0, $urandom_range(0, 17), 1'b0);
        add_beat(OP_POP,   32'h0, 32'h0, 1'b0, 0, 1'b0);
        add_beat(OP_FIND,  32'h0000_0001, 32'h0, 1'b0, 0, 1'b0);

        // random part: blocks that lean toward filling, draining or a mix
        for (blk = 0; blk < 25; blk++) begin
            mode     = $urandom_range(0, 2);
            tx_quiet = ($urandom_range(0, 3) == 0);
            for (k = 0; k < 60; k++) begin
                roll = $urandom_range(0, 99);
                case (mode)
                    0:       op = (roll < 70) ? OP_PUSH : (roll < 85) ? OP_FIND :
                                  (roll < 97) ? OP_POP  : OP_CLEAR;
                    1:       op = (roll < 25) ? OP_PUSH : (roll < 45) ? OP_FIND :
                                  (roll < 98) ? OP_POP  : OP_CLEAR;
                    default: op = (roll < 40) ? OP_PUSH : (roll < 65) ? OP_FIND :
                                  (roll < 96) ? OP_POP  : OP_CLEAR;
                endcase
                // reuse recent ids so finds hit and duplicates appear
                roll  = $urandom_range(0, 9);
                fresh = (id_pool.size() == 0) ||
                        (op == OP_FIND ? roll >= 7 : roll >= 4);
                if (fresh) begin
                    id = $urandom();
                end else begin
                    id = id_pool[$urandom_range(0, id_pool.size() - 1)];
                end
                // mostly narrow distances for ties, some wide and extreme
                roll = $urandom_range(0, 9);
                if (roll < 6) begin
                    dist_val = $urandom_range(0, 7);
                end else if (roll < 8) begin
                    dist_val = $urandom();
                end else if (roll == 8) begin
                    dist_val = '0;
                end else begin
                    dist_val = '1;
                end
                if (op == OP_PUSH && fresh) begin
                    id_pool.push_back(id);
                    if (id_pool.size() > 16) begin
                        id_pool.delete(0);
                    end
                end
                add_beat(op, id, dist_val, 1'($urandom_range(0, 1)),
                         tx_quiet ? 0 : $urandom_range(0, 17),
                         (k == 0) && (blk % 8 == 0));
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // everything sent and every result beat back
        do begin
            @(negedge i_clk);
        end while (pending_beats.size() != 0 || i_valid || expected_results.size() != 0);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (expected_results.size() != 0) begin
            $error("%0d result beats never arrived", expected_results.size());
            n_errors++;
        end
        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/cspq_pkg.sv
rtl/cspq_mem.sv
rtl/cspq_cmp.sv
rtl/cspq_seq.sv
rtl/sorted_candidate_priority_queue_top.sv
rtl/cspq_chk.sv
dv/sorted_candidate_priority_queue_top_tb.sv
